// ----- design/wavhdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhdr_pkg
// Shared types and constants of the wav header parser: status codes, tags,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package wavhdr_pkg;

   // result status codes
   typedef enum logic [3:0] {
      STAT_OK        = 4'd0,
      STAT_RIFF      = 4'd1,
      STAT_WAVE      = 4'd2,
      STAT_FMT_TAG   = 4'd3,
      STAT_FMT_SIZE  = 4'd4,
      STAT_NOT_PCM   = 4'd5,
      STAT_DATA_TAG  = 4'd6,
      STAT_ZERO_DIV  = 4'd7,
      STAT_NO_HEADER = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      DIV_CH    = 2'd0,
      DIV_RATE  = 2'd1,
      DIV_BYTES = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_DIV_CH,
      S_DIV_RATE,
      S_DIV_BYTES,
      S_MUL_CH,
      S_MUL_BYTES,
      S_ADD,
      S_OUT
   } ctrl_state_type;

   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_SEEK    = 1'b1;
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_SEEK   = 1'b1;

   localparam logic [5:0] HEADER_BYTES = 6'd44;
   localparam logic [63:0] HEADER_OFFSET = 64'd44;

   // tags stored with the first file byte in the low lane
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_SIZE = 32'h0000_0010;
   localparam logic [7:0]  PCM_LO   = 8'h01;
   localparam logic [7:0]  PCM_HI   = 8'h00;

   localparam logic [15:0] BITS_U8  = 16'd8;
   localparam logic [15:0] BITS_S16 = 16'd16;

   localparam logic [1:0] FMT_U8    = 2'd0;
   localparam logic [1:0] FMT_S16   = 2'd1;
   localparam logic [1:0] FMT_OTHER = 2'd2;

   typedef struct packed {
      logic        accept_byte;
      logic        accept_seek;
      logic        mul_ch;
      logic        mul_bytes;
      logic        add_hdr;
      logic        set_zero;
      logic        div_start;
      div_sel_type div_sel;
      logic        dur_load;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic hdr_report;
      logic hdr_err;
      logic hdr_valid;
      logic zero_div;
      logic div_done;
   } dp_sts_type;

endpackage

// ----- design/wav_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser
// Canonical 44-byte PCM WAV header checker with duration and seek offset.
// ----------------------------------------------------------------------------
// Header bytes are taken one per cycle and checked as they arrive; a byte that
// produces no report frees the block for the next request at once. At the
// first failing byte the controller goes straight to S_OUT, which loads the
// result register once it is free. After byte 44 the duration runs through a
// shared one-bit-per-cycle divider three times (length / channels / rate /
// bytes per sample), so a good header reports after the third division, or
// from S_PREP through S_OUT when a divisor is zero. A seek request runs one
// 32x32 multiply at acceptance, two saturating multiplies and the saturating
// add of the header size. The result register lets a finished report wait on
// rsp_stall while new header bytes keep arriving.
// ----------------------------------------------------------------------------
module wav_header_parser
   import wavhdr_pkg::*;
#(
   parameter int SECONDS_WIDTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic                     req_start_of_file,
   input  logic [7:0]               req_data_byte,
   input  logic [SECONDS_WIDTH-1:0] req_seek_seconds,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_kind,
   output logic [3:0]               rsp_status,
   output logic [7:0]               rsp_channels,
   output logic [31:0]              rsp_sample_rate,
   output logic [15:0]              rsp_bits_per_sample,
   output logic [1:0]               rsp_sample_format,
   output logic [31:0]              rsp_data_length,
   output logic [31:0]              rsp_duration_seconds,
   output logic [63:0]              rsp_seek_offset
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   wavhdr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   wavhdr_dp #(
      .SECONDS_WIDTH (SECONDS_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_start_of_file    (req_start_of_file),
      .req_data_byte        (req_data_byte),
      .req_seek_seconds     (req_seek_seconds),
      .rsp_kind             (rsp_kind),
      .rsp_status           (rsp_status),
      .rsp_channels         (rsp_channels),
      .rsp_sample_rate      (rsp_sample_rate),
      .rsp_bits_per_sample  (rsp_bits_per_sample),
      .rsp_sample_format    (rsp_sample_format),
      .rsp_data_length      (rsp_data_length),
      .rsp_duration_seconds (rsp_duration_seconds),
      .rsp_seek_offset      (rsp_seek_offset)
   );

endmodule

// ----- design/wavhdr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhdr_div
// Iterative restoring divider, 32-bit unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wavhdr_div
   import wavhdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[31]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = 5'd31;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 32'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider restarted while running");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff && $past(run_ff))
      else $error("divider done without a finished run");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> run_ff && cnt_ff == 5'd31)
      else $error("divider did not start");

endmodule

// ----- design/wavhdr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhdr_dp
// Datapath: header byte checks and field capture, duration division,
// saturating seek offset arithmetic and the result register.
// ----------------------------------------------------------------------------
module wavhdr_dp
   import wavhdr_pkg::*;
#(
   parameter int SECONDS_WIDTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic                     req_start_of_file,
   input  logic [7:0]               req_data_byte,
   input  logic [SECONDS_WIDTH-1:0] req_seek_seconds,
   output logic                     rsp_kind,
   output logic [3:0]               rsp_status,
   output logic [7:0]               rsp_channels,
   output logic [31:0]              rsp_sample_rate,
   output logic [15:0]              rsp_bits_per_sample,
   output logic [1:0]               rsp_sample_format,
   output logic [31:0]              rsp_data_length,
   output logic [31:0]              rsp_duration_seconds,
   output logic [63:0]              rsp_seek_offset
);

   function automatic status_type check_byte(input logic [5:0] pos, input logic [7:0] b);
      logic [4:0] lane;
      status_type st;
      lane = {pos[1:0], 3'b000};
      st   = STAT_OK;
      case (pos) inside
         [6'd0:6'd3]:   if (b != TAG_RIFF[lane +: 8]) st = STAT_RIFF;
         [6'd8:6'd11]:  if (b != TAG_WAVE[lane +: 8]) st = STAT_WAVE;
         [6'd12:6'd15]: if (b != TAG_FMT[lane +: 8])  st = STAT_FMT_TAG;
         [6'd16:6'd19]: if (b != FMT_SIZE[lane +: 8]) st = STAT_FMT_SIZE;
         6'd20:         if (b != PCM_LO)              st = STAT_NOT_PCM;
         6'd21:         if (b != PCM_HI)              st = STAT_NOT_PCM;
         [6'd36:6'd39]: if (b != TAG_DATA[lane +: 8]) st = STAT_DATA_TAG;
         default:       st = STAT_OK;
      endcase
      return st;
   endfunction

   // parse state
   logic [5:0]  pos_ff, pos_in;
   logic        stop_ff, stop_in;
   logic        valid_ff, valid_in;
   logic [7:0]  ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] len_ff, len_in;

   // work registers
   logic        kind_ff, kind_in;
   status_type  stat_ff, stat_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] dur_ff, dur_in;

   // result register
   logic        o_kind_ff;
   logic [3:0]  o_stat_ff;
   logic [7:0]  o_ch_ff;
   logic [31:0] o_rate_ff;
   logic [15:0] o_bits_ff;
   logic [1:0]  o_fmt_ff;
   logic [31:0] o_len_ff;
   logic [31:0] o_dur_ff;
   logic [63:0] o_off_ff;

   logic [5:0]  pos_eff, pos_nx;
   logic        stop_eff, valid_eff, live;
   logic [7:0]  ch_eff;
   logic [31:0] rate_eff, len_eff;
   logic [15:0] bits_eff;
   status_type  byte_stat;
   logic [4:0]  lane;

   logic [12:0] bytes_per;
   logic [31:0] secs32;
   logic [63:0] mul_rate;
   logic [71:0] mul_ch;
   logic [76:0] mul_bytes;
   logic [64:0] add_hdr;
   logic [1:0]  fmt_code;

   logic        div_done;
   logic [31:0] div_quo, div_dividend, div_divisor;

   assign bytes_per = bits_ff[15:3];
   assign secs32    = 32'(req_seek_seconds);
   assign mul_rate  = 64'(secs32) * 64'(rate_ff);
   assign mul_ch    = 72'(prod_ff) * 72'(ch_ff);
   assign mul_bytes = 77'(prod_ff) * 77'(bytes_per);
   assign add_hdr   = 65'(prod_ff) + 65'(HEADER_OFFSET);

   // start of file discards everything gathered so far
   always_comb begin
      pos_eff   = req_start_of_file ? '0 : pos_ff;
      stop_eff  = req_start_of_file ? 1'b0 : stop_ff;
      valid_eff = req_start_of_file ? 1'b0 : valid_ff;
      ch_eff    = req_start_of_file ? '0 : ch_ff;
      rate_eff  = req_start_of_file ? '0 : rate_ff;
      bits_eff  = req_start_of_file ? '0 : bits_ff;
      len_eff   = req_start_of_file ? '0 : len_ff;
      byte_stat = check_byte(pos_eff, req_data_byte);
      live      = !stop_eff && (pos_eff < HEADER_BYTES);
      pos_nx    = pos_eff + 6'd1;
      lane      = {pos_eff[1:0], 3'b000};
   end

   always_comb begin
      sts.hdr_report = live && (byte_stat != STAT_OK || pos_nx == HEADER_BYTES);
      sts.hdr_err    = live && (byte_stat != STAT_OK);
      sts.hdr_valid  = valid_ff;
      sts.zero_div   = (ch_ff == '0) || (rate_ff == '0) || (bytes_per == '0);
      sts.div_done   = div_done;
   end

   always_comb begin
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      valid_in = valid_ff;
      ch_in    = ch_ff;
      rate_in  = rate_ff;
      bits_in  = bits_ff;
      len_in   = len_ff;
      if (cmd.accept_byte) begin
         pos_in   = pos_eff;
         stop_in  = stop_eff;
         valid_in = valid_eff;
         ch_in    = ch_eff;
         rate_in  = rate_eff;
         bits_in  = bits_eff;
         len_in   = len_eff;
         if (live) begin
            if (byte_stat != STAT_OK) begin
               stop_in = 1'b1;
            end else begin
               pos_in = pos_nx;
               if (pos_nx == HEADER_BYTES) begin
                  stop_in  = 1'b1;
                  valid_in = 1'b1;
               end
            end
            case (pos_eff) inside
               6'd22:         ch_in = req_data_byte;
               [6'd24:6'd27]: rate_in[lane +: 8] = req_data_byte;
               [6'd34:6'd35]: bits_in[{pos_eff[0], 3'b000} +: 8] = req_data_byte;
               [6'd40:6'd43]: len_in[lane +: 8] = req_data_byte;
               default:       ch_in = ch_in;
            endcase
         end
      end
   end

   always_comb begin
      kind_in = kind_ff;
      stat_in = stat_ff;
      prod_in = prod_ff;
      dur_in  = dur_ff;
      if (cmd.accept_byte) begin
         kind_in = KIND_HEADER;
         stat_in = byte_stat;
         prod_in = '0;
         dur_in  = '0;
      end else if (cmd.accept_seek) begin
         kind_in = KIND_SEEK;
         stat_in = valid_ff ? STAT_OK : STAT_NO_HEADER;
         prod_in = valid_ff ? mul_rate : '0;
         dur_in  = '0;
      end else if (cmd.mul_ch) begin
         prod_in = (mul_ch[71:64] != '0) ? '1 : mul_ch[63:0];
      end else if (cmd.mul_bytes) begin
         prod_in = (mul_bytes[76:64] != '0) ? '1 : mul_bytes[63:0];
      end else if (cmd.add_hdr) begin
         prod_in = add_hdr[64] ? '1 : add_hdr[63:0];
      end else if (cmd.set_zero) begin
         stat_in = STAT_ZERO_DIV;
         dur_in  = '0;
      end else if (cmd.dur_load) begin
         dur_in = div_quo;
      end
   end

   always_comb begin
      div_dividend = div_quo;
      div_divisor  = 32'(ch_ff);
      case (cmd.div_sel)
         DIV_CH: begin
            div_dividend = len_ff;
            div_divisor  = 32'(ch_ff);
         end
         DIV_RATE:  div_divisor = rate_ff;
         DIV_BYTES: div_divisor = 32'(bytes_per);
         default:   div_divisor = 32'(ch_ff);
      endcase
   end

   wavhdr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      if (bits_ff == BITS_U8) begin
         fmt_code = FMT_U8;
      end else if (bits_ff == BITS_S16) begin
         fmt_code = FMT_S16;
      end else begin
         fmt_code = FMT_OTHER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         stop_ff  <= 1'b0;
         valid_ff <= 1'b0;
         ch_ff    <= '0;
         rate_ff  <= '0;
         bits_ff  <= '0;
         len_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
         valid_ff <= valid_in;
         ch_ff    <= ch_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      stat_ff <= stat_in;
      prod_ff <= prod_in;
      dur_ff  <= dur_in;
   end

   // a seek report carries only kind, status and offset
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_kind_ff <= kind_ff;
         o_stat_ff <= stat_ff;
         if (kind_ff == KIND_SEEK) begin
            o_ch_ff   <= '0;
            o_rate_ff <= '0;
            o_bits_ff <= '0;
            o_fmt_ff  <= '0;
            o_len_ff  <= '0;
            o_dur_ff  <= '0;
            o_off_ff  <= prod_ff;
         end else begin
            o_ch_ff   <= ch_ff;
            o_rate_ff <= rate_ff;
            o_bits_ff <= bits_ff;
            o_fmt_ff  <= fmt_code;
            o_len_ff  <= len_ff;
            o_dur_ff  <= dur_ff;
            o_off_ff  <= '0;
         end
      end
   end

   assign rsp_kind             = o_kind_ff;
   assign rsp_status           = o_stat_ff;
   assign rsp_channels         = o_ch_ff;
   assign rsp_sample_rate      = o_rate_ff;
   assign rsp_bits_per_sample  = o_bits_ff;
   assign rsp_sample_format    = o_fmt_ff;
   assign rsp_data_length      = o_len_ff;
   assign rsp_duration_seconds = o_dur_ff;
   assign rsp_seek_offset      = o_off_ff;

endmodule

// ----- design/wavhdr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhdr_ctrl
// Controller: request acceptance, division and multiply sequencing, and the
// result handshake.
// ----------------------------------------------------------------------------
module wavhdr_ctrl
   import wavhdr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_SEEK) begin
                  state_in = sts.hdr_valid ? S_MUL_CH : S_OUT;
               end else if (sts.hdr_report) begin
                  state_in = sts.hdr_err ? S_OUT : S_PREP;
               end
            end
         end
         S_PREP:      state_in = sts.zero_div ? S_OUT : S_DIV_CH;
         S_DIV_CH:    if (sts.div_done) state_in = S_DIV_RATE;
         S_DIV_RATE:  if (sts.div_done) state_in = S_DIV_BYTES;
         S_DIV_BYTES: if (sts.div_done) state_in = S_OUT;
         S_MUL_CH:    state_in = S_MUL_BYTES;
         S_MUL_BYTES: state_in = S_ADD;
         S_ADD:       state_in = S_OUT;
         S_OUT:       if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept_byte = 1'b0;
      cmd.accept_seek = 1'b0;
      cmd.mul_ch      = 1'b0;
      cmd.mul_bytes   = 1'b0;
      cmd.add_hdr     = 1'b0;
      cmd.set_zero    = 1'b0;
      cmd.div_start   = 1'b0;
      cmd.div_sel     = DIV_CH;
      cmd.dur_load    = 1'b0;
      cmd.load_out    = 1'b0;
      req_stall       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept_seek = (req_action == ACT_SEEK);
               cmd.accept_byte = (req_action == ACT_BYTE);
            end
         end
         S_PREP: begin
            cmd.set_zero  = sts.zero_div;
            cmd.div_start = !sts.zero_div;
            cmd.div_sel   = DIV_CH;
         end
         S_DIV_CH: begin
            cmd.div_sel   = DIV_RATE;
            cmd.div_start = sts.div_done;
         end
         S_DIV_RATE: begin
            cmd.div_sel   = DIV_BYTES;
            cmd.div_start = sts.div_done;
         end
         S_DIV_BYTES: begin
            cmd.div_sel  = DIV_BYTES;
            cmd.dur_load = sts.div_done;
         end
         S_MUL_CH:    cmd.mul_ch    = 1'b1;
         S_MUL_BYTES: cmd.mul_bytes = 1'b1;
         S_ADD:       cmd.add_hdr   = 1'b1;
         S_OUT:       cmd.load_out  = out_free;
         default:     req_stall     = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("loaded result not presented");

   a_last_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_BYTES && sts.div_done) |=> state_ff == S_OUT)
      else $error("duration sequence did not finish");

endmodule

// ----- bench/tb_wav_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_header_parser
// Streams WAV headers and seek requests into the parser: a directed plan of
// tag errors, zero divisors and saturating seeks, then random headers that
// are mostly well formed, with corrupted, cut-off and stray bytes mixed in.
// Every report is checked against a cycle-free predictor kept in the bench or a fixed plan report.
// ----------------------------------------------------------------------------
module tb_wav_header_parser;
   import wavhdr_pkg::*;

   localparam int CLEAN   = -1;   // header row without a corrupted byte
   localparam int PREDICT = -1;   // row whose report comes from the predictor

   typedef struct packed {
      logic        kind;
      status_type  status;
      logic [7:0]  channels;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic [1:0]  sample_format;
      logic [31:0] data_length;
      logic [31:0] duration_seconds;
      logic [63:0] seek_offset;
   } wav_rsp_type;

   typedef enum logic [1:0] {DO_SEEK, DO_BYTE, DO_HEADER} row_op_type;

   typedef struct {
      row_op_type  op;
      logic        sof;
      logic [7:0]  byt;
      logic [15:0] secs;
      logic [7:0]  ch;
      logic [31:0] rate;
      logic [15:0] bits;
      logic [31:0] len;
      int          bad_pos;
      int          fixed_status;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ACT_BYTE;
   logic        req_start_of_file = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic [15:0] req_seek_seconds = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [3:0]  rsp_status;
   logic [7:0]  rsp_channels;
   logic [31:0] rsp_sample_rate;
   logic [15:0] rsp_bits_per_sample;
   logic [1:0]  rsp_sample_format;
   logic [31:0] rsp_data_length;
   logic [31:0] rsp_duration_seconds;
   logic [63:0] rsp_seek_offset;

   // predictor state
   logic [5:0]  hdr_pos = '0;
   logic        hdr_stopped = 1'b0;
   logic        hdr_ok = 1'b0;
   logic [7:0]  hdr_ch = '0;
   logic [31:0] hdr_rate = '0;
   logic [15:0] hdr_bits = '0;
   logic [31:0] hdr_len = '0;
   logic        ignored_req = 1'b0;

   wav_rsp_type  expected_reports[$];
   plan_row_type plan[$];
   int           taken = 0;
   int           mismatches = 0;
   int           phase = 0;

   wav_header_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_start_of_file    (req_start_of_file),
      .req_data_byte        (req_data_byte),
      .req_seek_seconds     (req_seek_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_status           (rsp_status),
      .rsp_channels         (rsp_channels),
      .rsp_sample_rate      (rsp_sample_rate),
      .rsp_bits_per_sample  (rsp_bits_per_sample),
      .rsp_sample_format    (rsp_sample_format),
      .rsp_data_length      (rsp_data_length),
      .rsp_duration_seconds (rsp_duration_seconds),
      .rsp_seek_offset      (rsp_seek_offset)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver stalls most first, sender idles most next, then neither
   function automatic int idle_pct(input bit sender);
      case (phase)
         0:       return sender ? 29 : 74;
         1:       return sender ? 74 : 29;
         default: return 0;
      endcase
   endfunction

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct(1'b0));
   end

   function automatic wav_rsp_type fixed_report(input logic kind, input status_type st);
      wav_rsp_type r;
      r = '0;
      r.kind = kind;
      r.status = st;
      // bits read 0 before byte 34, so the format code is "other"
      if (kind == KIND_HEADER) begin
         r.sample_format = FMT_OTHER;
      end
      return r;
   endfunction

   function automatic wav_rsp_type header_summary(input status_type st);
      wav_rsp_type r;
      logic [15:0] nbytes;
      r = '0;
      nbytes = hdr_bits / 16'd8;
      r.kind = KIND_HEADER;
      r.status = st;
      r.channels = hdr_ch;
      r.sample_rate = hdr_rate;
      r.bits_per_sample = hdr_bits;
      r.data_length = hdr_len;
      if (hdr_bits == BITS_U8) begin
         r.sample_format = FMT_U8;
      end else if (hdr_bits == BITS_S16) begin
         r.sample_format = FMT_S16;
      end else begin
         r.sample_format = FMT_OTHER;
      end
      if (st == STAT_OK) begin
         if (hdr_ch == 0 || hdr_rate == 0 || nbytes == 0) begin
            r.status = STAT_ZERO_DIV;
         end else begin
            r.duration_seconds = ((hdr_len / {24'd0, hdr_ch}) / hdr_rate) / {16'd0, nbytes};
         end
      end
      return r;
   endfunction

   // advances the parser state by one request; returns 1 when a report is due
   function automatic bit parse_step(input logic act, input logic sof, input logic [7:0] b,
                                     input logic [15:0] secs, output wav_rsp_type r);
      status_type   st;
      logic [127:0] prod;
      r = '0;
      ignored_req = 1'b0;
      if (act == ACT_SEEK) begin
         r.kind = KIND_SEEK;
         if (!hdr_ok) begin
            r.status = STAT_NO_HEADER;
            return 1'b1;
         end
         r.status = STAT_OK;
         prod = 128'(secs) * 128'(hdr_rate) * 128'(hdr_ch) * 128'(hdr_bits / 16'd8);
         if (prod > 128'(64'hFFFF_FFFF_FFFF_FFFF - HEADER_OFFSET)) begin
            r.seek_offset = '1;
         end else begin
            r.seek_offset = prod[63:0] + HEADER_OFFSET;
         end
         return 1'b1;
      end
      if (sof) begin
         hdr_pos = '0;
         hdr_stopped = 1'b0;
         hdr_ok = 1'b0;
         hdr_ch = '0;
         hdr_rate = '0;
         hdr_bits = '0;
         hdr_len = '0;
      end
      if (hdr_stopped || hdr_pos >= HEADER_BYTES) begin
         ignored_req = 1'b1;
         return 1'b0;
      end
      st = STAT_OK;
      if (hdr_pos < 4) begin
         if (b != TAG_RIFF[8*hdr_pos[1:0] +: 8]) st = STAT_RIFF;
      end else if (hdr_pos >= 8 && hdr_pos < 12) begin
         if (b != TAG_WAVE[8*hdr_pos[1:0] +: 8]) st = STAT_WAVE;
      end else if (hdr_pos >= 12 && hdr_pos < 16) begin
         if (b != TAG_FMT[8*hdr_pos[1:0] +: 8]) st = STAT_FMT_TAG;
      end else if (hdr_pos >= 16 && hdr_pos < 20) begin
         if (b != FMT_SIZE[8*hdr_pos[1:0] +: 8]) st = STAT_FMT_SIZE;
      end else if (hdr_pos == 20) begin
         if (b != PCM_LO) st = STAT_NOT_PCM;
      end else if (hdr_pos == 21) begin
         if (b != PCM_HI) st = STAT_NOT_PCM;
      end else if (hdr_pos == 22) begin
         hdr_ch = b;
      end else if (hdr_pos >= 24 && hdr_pos < 28) begin
         hdr_rate[8*hdr_pos[1:0] +: 8] = b;
      end else if (hdr_pos == 34 || hdr_pos == 35) begin
         hdr_bits[8*hdr_pos[0] +: 8] = b;
      end else if (hdr_pos >= 36 && hdr_pos < 40) begin
         if (b != TAG_DATA[8*hdr_pos[1:0] +: 8]) st = STAT_DATA_TAG;
      end else if (hdr_pos >= 40) begin
         hdr_len[8*hdr_pos[1:0] +: 8] = b;
      end
      if (st != STAT_OK) begin
         hdr_stopped = 1'b1;
         r = header_summary(st);
         return 1'b1;
      end
      hdr_pos = hdr_pos + 6'd1;
      if (hdr_pos == HEADER_BYTES) begin
         hdr_stopped = 1'b1;
         hdr_ok = 1'b1;
         r = header_summary(STAT_OK);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(input logic act, input logic sof, input logic [7:0] b,
                           input logic [15:0] secs, input int fixed_status);
      wav_rsp_type r;
      bit          due;
      while ($urandom_range(99) < idle_pct(1'b1)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_start_of_file <= sof;
      req_data_byte <= b;
      req_seek_seconds <= secs;
      do @(posedge clock); while (req_stall);
      due = parse_step(act, sof, b, secs, r);
      if (!ignored_req) taken++;
      if (due) begin
         if (fixed_status != PREDICT) begin
            r = fixed_report(act == ACT_SEEK ? KIND_SEEK : KIND_HEADER,
                             status_type'(fixed_status));
         end
         expected_reports.push_back(r);
      end
      phase = (taken < 170) ? 0 : (taken < 340) ? 1 : 2;
      @(negedge clock);
   endtask

   // sends bytes 0..count-1, or up to and including a corrupted byte
   task automatic send_header(input logic [7:0] ch, input logic [31:0] rate,
                              input logic [15:0] bits, input logic [31:0] len,
                              input int bad_pos, input int count, input int fixed_status);
      logic [7:0] hdr [44];
      int         last;
      for (int i = 0; i < 44; i++) hdr[i] = 8'($urandom);
      for (int i = 0; i < 4; i++) begin
         hdr[i]      = TAG_RIFF[8*i +: 8];
         hdr[8 + i]  = TAG_WAVE[8*i +: 8];
         hdr[12 + i] = TAG_FMT[8*i +: 8];
         hdr[16 + i] = FMT_SIZE[8*i +: 8];
         hdr[24 + i] = rate[8*i +: 8];
         hdr[36 + i] = TAG_DATA[8*i +: 8];
         hdr[40 + i] = len[8*i +: 8];
      end
      hdr[20] = PCM_LO;
      hdr[21] = PCM_HI;
      hdr[22] = ch;
      hdr[34] = bits[7:0];
      hdr[35] = bits[15:8];
      last = count - 1;
      if (bad_pos != CLEAN) begin
         hdr[bad_pos] ^= 8'($urandom_range(1, 255));
         last = bad_pos;
      end
      for (int i = 0; i <= last; i++) begin
         send_req(ACT_BYTE, i == 0, hdr[i], 16'($urandom), fixed_status);
      end
   endtask

   function automatic void add_row(input row_op_type op, input logic sof, input logic [7:0] byt,
                                   input logic [15:0] secs, input logic [7:0] ch,
                                   input logic [31:0] rate, input logic [15:0] bits,
                                   input logic [31:0] len, input int bad_pos,
                                   input int fixed_status);
      plan_row_type row;
      row.op = op;
      row.sof = sof;
      row.byt = byt;
      row.secs = secs;
      row.ch = ch;
      row.rate = rate;
      row.bits = bits;
      row.len = len;
      row.bad_pos = bad_pos;
      row.fixed_status = fixed_status;
      plan.push_back(row);
   endfunction

   function automatic string show_rsp(input wav_rsp_type r);
      return $sformatf("kind=%0d status=%0d ch=%0d rate=%0d bits=%0d fmt=%0d len=%0d dur=%0d off=%0h",
                       r.kind, r.status, r.channels, r.sample_rate, r.bits_per_sample,
                       r.sample_format, r.data_length, r.duration_seconds, r.seek_offset);
   endfunction

   always @(posedge clock) begin : rsp_check
      wav_rsp_type seen;
      wav_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind = rsp_kind;
         seen.status = status_type'(rsp_status);
         seen.channels = rsp_channels;
         seen.sample_rate = rsp_sample_rate;
         seen.bits_per_sample = rsp_bits_per_sample;
         seen.sample_format = rsp_sample_format;
         seen.data_length = rsp_data_length;
         seen.duration_seconds = rsp_duration_seconds;
         seen.seek_offset = rsp_seek_offset;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected report: %s", show_rsp(seen));
         end else begin
            want = expected_reports.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("report mismatch at %0t", $time);
                  $display("  expected %s", show_rsp(want));
                  $display("  actual   %s", show_rsp(seen));
               end
            end
         end
      end
   end

   initial begin : stimulus
      int          base_taken;
      int          pick;
      int          bad;
      int          count;
      int          nseek;
      logic [7:0]  ch;
      logic [31:0] rate;
      logic [15:0] bits;
      logic [31:0] len;
      logic [15:0] secs;

      //      op         sof   byte   secs      ch     rate           bits      length
      add_row(DO_SEEK,   1'b0, 8'h00, 16'h0000, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, STAT_NO_HEADER);
      add_row(DO_SEEK,   1'b1, 8'h00, 16'hFFFF, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, STAT_NO_HEADER);
      add_row(DO_BYTE,   1'b1, 8'h00, 16'h0000, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, STAT_RIFF);
      // stray byte after an error report
      add_row(DO_BYTE,   1'b0, 8'hFF, 16'h0000, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd44100,     16'd16,   32'd1764000,
              CLEAN, PREDICT);
      add_row(DO_SEEK,   1'b0, 8'h00, 16'h0000, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);
      add_row(DO_SEEK,   1'b1, 8'h00, 16'hFFFF, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd1,  32'd8000,      16'd8,    32'hFFFF_FFFF,
              CLEAN, PREDICT);
      // stray byte after a full header
      add_row(DO_BYTE,   1'b0, 8'h52, 16'h0000, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);
      add_row(DO_SEEK,   1'b0, 8'h00, 16'h0001, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
              CLEAN, PREDICT);
      // offset saturates
      add_row(DO_SEEK,   1'b0, 8'h00, 16'hFFFF, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);
      // zero divisors, header still good for seeks
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd0,  32'd48000,     16'd24,   32'd1000,
              CLEAN, PREDICT);
      add_row(DO_SEEK,   1'b0, 8'h00, 16'd100,  8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd0,         16'd16,   32'd5000,
              CLEAN, PREDICT);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd48000,     16'd7,    32'd5000,
              CLEAN, PREDICT);
      // tag and format errors
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd48000,     16'd16,   32'd5000,
              8, STAT_WAVE);
      add_row(DO_SEEK,   1'b0, 8'h00, 16'd3,    8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, STAT_NO_HEADER);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd48000,     16'd16,   32'd5000,
              12, STAT_FMT_TAG);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd48000,     16'd16,   32'd5000,
              16, STAT_FMT_SIZE);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd48000,     16'd16,   32'd5000,
              20, STAT_NOT_PCM);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd48000,     16'd16,   32'd5000,
              21, STAT_NOT_PCM);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd6,  32'd96000,     16'd32,   32'd5000,
              36, PREDICT);
      add_row(DO_HEADER, 1'b1, 8'h00, 16'h0000, 8'd2,  32'd48000,     16'd16,   32'd5000,
              3, STAT_RIFF);
      // restart, left in the middle of a parse
      add_row(DO_BYTE,   1'b1, 8'h52, 16'h0000, 8'd0,  32'd0,         16'd0,    32'd0,
              CLEAN, PREDICT);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].op)
            DO_SEEK: send_req(ACT_SEEK, plan[i].sof, 8'h00, plan[i].secs, plan[i].fixed_status);
            DO_BYTE: send_req(ACT_BYTE, plan[i].sof, plan[i].byt, 16'h0000,
                              plan[i].fixed_status);
            default: send_header(plan[i].ch, plan[i].rate, plan[i].bits, plan[i].len,
                                 plan[i].bad_pos, int'(HEADER_BYTES), plan[i].fixed_status);
         endcase
      end

      // the directed plan sends about 400 requests, the random part the rest
      base_taken = taken;
      while (taken - base_taken < 100) begin
         case ($urandom_range(9))
            0:       ch = 8'd0;
            1, 2, 3: ch = 8'd1;
            4, 5, 6: ch = 8'd2;
            default: ch = 8'($urandom);
         endcase
         case ($urandom_range(9))
            0:       rate = 32'd0;
            1:       rate = 32'hFFFF_FFFF;
            2:       rate = 32'd8000;
            3:       rate = 32'd44100;
            4:       rate = 32'd48000;
            5:       rate = 32'($urandom_range(1, 255));
            default: rate = $urandom;
         endcase
         case ($urandom_range(9))
            0:       bits = 16'($urandom_range(0, 7));
            1, 2:    bits = BITS_U8;
            3, 4:    bits = BITS_S16;
            5:       bits = 16'd24;
            6:       bits = 16'd32;
            7:       bits = 16'hFFFF;
            default: bits = 16'($urandom);
         endcase
         case ($urandom_range(4))
            0:       len = 32'd0;
            1:       len = 32'hFFFF_FFFF;
            2:       len = 32'($urandom_range(0, 1000));
            default: len = $urandom;
         endcase

         pick = $urandom_range(99);
         if (pick < 55) begin
            send_header(ch, rate, bits, len, CLEAN, int'(HEADER_BYTES), PREDICT);
         end else if (pick < 70) begin
            // only positions that are checked can break the parse
            do bad = $urandom_range(39);
            while ((bad >= 4 && bad < 8) || (bad >= 22 && bad < 36));
            send_header(ch, rate, bits, len, bad, int'(HEADER_BYTES), PREDICT);
         end else if (pick < 78) begin
            count = $urandom_range(1, 43);
            send_header(ch, rate, bits, len, CLEAN, count, PREDICT);
         end else if (pick < 85) begin
            count = $urandom_range(1, 6);
            repeat (count) begin
               send_req(ACT_BYTE, $urandom_range(9) == 0, 8'($urandom), 16'($urandom),
                        PREDICT);
            end
         end

         nseek = $urandom_range(3);
         repeat (nseek) begin
            case ($urandom_range(4))
               0:       secs = 16'h0000;
               1:       secs = 16'hFFFF;
               default: secs = 16'($urandom);
            endcase
            send_req(ACT_SEEK, 1'($urandom_range(1)), 8'($urandom), secs, PREDICT);
         end
      end

      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
